// ----- rtl/lmt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and codes for the LRU month table.
package lmt_pkg;

    // Field widths
    localparam int YEAR_W    = 14;
    localparam int MONTH_W   = 4;
    localparam int KEY_W     = YEAR_W + MONTH_W;
    localparam int STAMP_W   = 32;
    localparam int MAXE_W    = 5;
    localparam int CAUSE_W   = 2;

    // Table and result limits
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int NRES_W          = $clog2(MAX_RESULTS + 1);

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [STAMP_W-1:0] TIMEOUT_RST = 32'd3600;
    localparam logic [MAXE_W-1:0]  MAXE_RST    = 5'd0;

    // Register select, taken from paddr bit 2
    typedef enum logic {
        REG_TIMEOUT = 1'b0,
        REG_MAXE    = 1'b1
    } reg_sel_t;

    // Eviction cause codes
    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_TIMEOUT = 2'd1,
        CAUSE_SIZE    = 2'd2,
        CAUSE_FULL    = 2'd3
    } cause_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic   load;
        logic   pos_inc;
        logic   pos_to_count;
        logic   pos_to_last;
        logic   ram_rd;
        logic   sel_last;
        logic   touch;
        logic   cnt_inc;
        logic   cnt_dec;
        logic   emit;
        logic   finish;
        cause_t cause;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic key_zero;
        logic evict_req;
        logic count_zero;
        logic count_full;
        logic pos_is_last;
        logic key_match;
        logic timed_out;
        logic size_over;
        logic nres_full;
    } ctrl_stat_t;

endpackage

// ----- rtl/lmt_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module lmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/lmt_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for lookup, touch, eviction passes and result flush.
module lmt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  lmt_pkg::ctrl_stat_t   stat,
    output lmt_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_DISPATCH  = 13'b0000000000010,
        S_LK_RD     = 13'b0000000000100,
        S_LK_CMP    = 13'b0000000001000,
        S_HIT       = 13'b0000000010000,
        S_FULL_RD   = 13'b0000000100000,
        S_FULL_EMIT = 13'b0000001000000,
        S_INSERT    = 13'b0000010000000,
        S_TMO_RD    = 13'b0000100000000,
        S_TMO_CHK   = 13'b0001000000000,
        S_SZ_RD     = 13'b0010000000000,
        S_SZ_EMIT   = 13'b0100000000000,
        S_FINISH    = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.cause  = lmt_pkg::CAUSE_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.key_zero)
                begin
                    state_next = stat.evict_req ? S_TMO_RD : S_FINISH;
                end
                else if (stat.count_zero)
                begin
                    cmd.pos_to_count = 1'b1;
                    state_next       = S_INSERT;
                end
                else
                begin
                    state_next = S_LK_RD;
                end
            end
            S_LK_RD:
            begin
                cmd.ram_rd = 1'b1;
                state_next = S_LK_CMP;
            end
            S_LK_CMP:
            begin
                if (stat.key_match)
                begin
                    state_next = S_HIT;
                end
                else if (stat.pos_is_last)
                begin
                    if (stat.count_full)
                    begin
                        state_next = S_FULL_RD;
                    end
                    else
                    begin
                        cmd.pos_to_count = 1'b1;
                        state_next       = S_INSERT;
                    end
                end
                else
                begin
                    cmd.pos_inc = 1'b1;
                    state_next  = S_LK_RD;
                end
            end
            S_HIT:
            begin
                cmd.touch  = 1'b1;
                state_next = stat.evict_req ? S_TMO_RD : S_FINISH;
            end
            S_FULL_RD:
            begin
                cmd.ram_rd   = 1'b1;
                cmd.sel_last = 1'b1;
                state_next   = S_FULL_EMIT;
            end
            S_FULL_EMIT:
            begin
                cmd.emit        = 1'b1;
                cmd.cause       = lmt_pkg::CAUSE_FULL;
                cmd.cnt_dec     = 1'b1;
                cmd.pos_to_last = 1'b1;
                state_next      = S_INSERT;
            end
            S_INSERT:
            begin
                cmd.touch   = 1'b1;
                cmd.cnt_inc = 1'b1;
                state_next  = stat.evict_req ? S_TMO_RD : S_FINISH;
            end
            S_TMO_RD:
            begin
                if (stat.count_zero || stat.nres_full)
                begin
                    state_next = S_SZ_RD;
                end
                else
                begin
                    cmd.ram_rd   = 1'b1;
                    cmd.sel_last = 1'b1;
                    state_next   = S_TMO_CHK;
                end
            end
            S_TMO_CHK:
            begin
                if (stat.timed_out)
                begin
                    cmd.emit    = 1'b1;
                    cmd.cause   = lmt_pkg::CAUSE_TIMEOUT;
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_TMO_RD;
                end
                else
                begin
                    state_next = S_SZ_RD;
                end
            end
            S_SZ_RD:
            begin
                if (!stat.size_over || stat.nres_full)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.ram_rd   = 1'b1;
                    cmd.sel_last = 1'b1;
                    state_next   = S_SZ_EMIT;
                end
            end
            S_SZ_EMIT:
            begin
                cmd.emit    = 1'b1;
                cmd.cause   = lmt_pkg::CAUSE_SIZE;
                cmd.cnt_dec = 1'b1;
                state_next  = S_SZ_RD;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/lmt_dpath.sv -----
`timescale 1ns / 1ps
// Datapath: recency order list, key/stamp RAM, counters and result staging.
module lmt_dpath #(
    parameter int TABLE_DEPTH = lmt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lmt_pkg::ctrl_cmd_t             cmd,
    output lmt_pkg::ctrl_stat_t            stat,
    input  logic [lmt_pkg::YEAR_W-1:0]     in_year,
    input  logic [lmt_pkg::MONTH_W-1:0]    in_month,
    input  logic [lmt_pkg::STAMP_W-1:0]    in_now,
    input  logic                           in_evict,
    input  logic [lmt_pkg::STAMP_W-1:0]    timeout,
    input  logic [lmt_pkg::MAXE_W-1:0]     max_entries,
    output logic                           out_strobe,
    output logic                           out_valid,
    output logic [lmt_pkg::YEAR_W-1:0]     out_year,
    output logic [lmt_pkg::MONTH_W-1:0]    out_month,
    output logic [lmt_pkg::CAUSE_W-1:0]    out_cause,
    output logic                           out_last
);

    localparam int PW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW  = (CW > lmt_pkg::MAXE_W) ? CW : lmt_pkg::MAXE_W;
    localparam int KW    = lmt_pkg::KEY_W;
    localparam int SW    = lmt_pkg::STAMP_W;
    localparam int RAM_W = KW + SW;

    // Item registers
    logic [KW-1:0]              key_reg;
    logic [SW-1:0]              now_reg;
    logic                       evict_reg;

    // Table bookkeeping
    logic [CW-1:0]              count_reg;
    logic [PW-1:0]              pos_reg;
    logic [lmt_pkg::NRES_W-1:0] nres_reg;
    logic [PW-1:0]              ord_reg [TABLE_DEPTH];

    // Result staging
    logic                       pend_valid_reg;
    logic [KW-1:0]              pend_key_reg;
    lmt_pkg::cause_t            pend_cause_reg;
    logic                       out_strobe_reg;
    logic                       out_valid_reg;
    logic [KW-1:0]              out_key_reg;
    lmt_pkg::cause_t            out_cause_reg;
    logic                       out_last_reg;

    logic [CW-1:0]              cnt_m1;
    logic [PW-1:0]              rd_idx;
    logic [PW-1:0]              ord_sel;
    logic [RAM_W-1:0]           rd_data;
    logic [KW-1:0]              rd_key;
    logic [SW-1:0]              rd_stamp;
    logic [SW:0]                age;

    assign cnt_m1 = count_reg - CW'(1);

    // Slot select: position counter, or least recent position
    always_comb
    begin
        rd_idx  = cmd.sel_last ? cnt_m1[PW-1:0] : pos_reg;
        ord_sel = '0;
        if (int'(rd_idx) < TABLE_DEPTH)
        begin
            ord_sel = ord_reg[rd_idx];
        end
    end

    // Key and stamp storage, one word per slot
    lmt_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.touch),
        .waddr (ord_sel),
        .wdata ({key_reg, now_reg}),
        .re    (cmd.ram_rd),
        .raddr (ord_sel),
        .rdata (rd_data)
    );

    assign rd_key   = rd_data[SW +: KW];
    assign rd_stamp = rd_data[SW-1:0];

    // Age with borrow; a borrow means time went backwards
    assign age = {1'b0, now_reg} - {1'b0, rd_stamp};

    // Status toward the controller
    always_comb
    begin
        stat.key_zero    = (key_reg == '0);
        stat.evict_req   = evict_reg;
        stat.count_zero  = (count_reg == '0);
        stat.count_full  = (count_reg == CW'(TABLE_DEPTH));
        stat.pos_is_last = (pos_reg == cnt_m1[PW-1:0]);
        stat.key_match   = (rd_key == key_reg);
        stat.timed_out   = !age[SW] && (age[SW-1:0] >= timeout);
        stat.size_over   = (max_entries != '0) &&
                           (CMPW'(count_reg) > CMPW'(max_entries));
        stat.nres_full   = (nres_reg == lmt_pkg::NRES_W'(lmt_pkg::MAX_RESULTS));
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg   <= {in_year, in_month};
            now_reg   <= in_now;
            evict_reg <= in_evict;
        end
    end

    // Counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pos_reg   <= '0;
            nres_reg  <= '0;
        end
        else
        begin
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= cnt_m1;
            end

            if (cmd.load)
            begin
                pos_reg <= '0;
            end
            else if (cmd.pos_inc)
            begin
                pos_reg <= pos_reg + PW'(1);
            end
            else if (cmd.pos_to_count)
            begin
                pos_reg <= count_reg[PW-1:0];
            end
            else if (cmd.pos_to_last)
            begin
                pos_reg <= cnt_m1[PW-1:0];
            end

            if (cmd.load)
            begin
                nres_reg <= '0;
            end
            else if (cmd.emit)
            begin
                nres_reg <= nres_reg + lmt_pkg::NRES_W'(1);
            end
        end
    end

    // Recency order: position 0 most recent, free slots beyond the count.
    // A touch moves the slot at pos_reg to the front.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < TABLE_DEPTH; p++)
            begin
                ord_reg[p] <= PW'(p);
            end
        end
        else if (cmd.touch)
        begin
            ord_reg[0] <= ord_sel;
            for (int p = 1; p < TABLE_DEPTH; p++)
            begin
                if (PW'(p) <= pos_reg)
                begin
                    ord_reg[p] <= ord_reg[p-1];
                end
            end
        end
    end

    // Result staging: hold one eviction until it is known whether it is last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_key_reg   <= '0;
            pend_cause_reg <= lmt_pkg::CAUSE_NONE;
            out_strobe_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_key_reg    <= '0;
            out_cause_reg  <= lmt_pkg::CAUSE_NONE;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            out_strobe_reg <= 1'b0;
            if (cmd.emit)
            begin
                if (pend_valid_reg)
                begin
                    out_strobe_reg <= 1'b1;
                    out_valid_reg  <= 1'b1;
                    out_key_reg    <= pend_key_reg;
                    out_cause_reg  <= pend_cause_reg;
                    out_last_reg   <= 1'b0;
                end
                pend_valid_reg <= 1'b1;
                pend_key_reg   <= rd_key;
                pend_cause_reg <= cmd.cause;
            end
            else if (cmd.finish)
            begin
                out_strobe_reg <= 1'b1;
                out_last_reg   <= 1'b1;
                pend_valid_reg <= 1'b0;
                if (pend_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                    out_key_reg   <= pend_key_reg;
                    out_cause_reg <= pend_cause_reg;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                    out_key_reg   <= '0;
                    out_cause_reg <= lmt_pkg::CAUSE_NONE;
                end
            end
        end
    end

    assign out_strobe = out_strobe_reg;
    assign out_valid  = out_valid_reg;
    assign out_year   = out_key_reg[KW-1:lmt_pkg::MONTH_W];
    assign out_month  = out_key_reg[lmt_pkg::MONTH_W-1:0];
    assign out_cause  = out_cause_reg;
    assign out_last   = out_last_reg;

endmodule

// ----- rtl/lru_month_table_with_timeout_top.sv -----
`timescale 1ns / 1ps
// Top level: LRU table of (year, month) keys with timeout and size eviction.
//
// Usage:
//   An item (year, month, now_seconds, do_evict) is taken at a rising edge
//   with start high and busy low. A nonzero key is looked up and moved to
//   the most recent place, or inserted (first evicting one if full).
//   With do_evict set, least recent entries are then evicted while timed
//   out, then while the count is above a nonzero max_entries (up to 16 per item).
//   Each result word is shown for one cycle with result_valid high; the
//   receiver cannot stall, so every word must be taken on that cycle.
//   last_result marks the final word of an item; an item with no eviction
//   gives one word with evicted_valid low.
//   Steps with busy high: dispatch, a lookup that compares one entry at a
//   time (one RAM read port), touch, a table-full eviction if needed,
//   timeout and size evictions, the checks that end the two passes, and
//   flush. Items go one at a time: the next start is taken once busy is
//   low. The last word shows in the first cycle busy is low.
//   Reset empties the table (no RAM clearing pass is needed) and loads
//   timeout_seconds = 3600, max_entries = 0. Registers sit on the APB port
//   at byte 0 and 4 and should be written only while busy is low.
module lru_month_table_with_timeout_top #(
    parameter int TABLE_DEPTH = lmt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Item channel
    input  logic                              start,
    output logic                              busy,
    input  logic [lmt_pkg::YEAR_W-1:0]        year,
    input  logic [lmt_pkg::MONTH_W-1:0]       month,
    input  logic [lmt_pkg::STAMP_W-1:0]       now_seconds,
    input  logic                              do_evict,
    // Result channel
    output logic                              result_valid,
    output logic                              evicted_valid,
    output logic [lmt_pkg::YEAR_W-1:0]        evicted_year,
    output logic [lmt_pkg::MONTH_W-1:0]       evicted_month,
    output logic [lmt_pkg::CAUSE_W-1:0]       evict_cause,
    output logic                              last_result,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lmt_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lmt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lmt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    logic [lmt_pkg::STAMP_W-1:0] timeout_reg;
    logic [lmt_pkg::MAXE_W-1:0]  max_entries_reg;
    lmt_pkg::reg_sel_t           reg_sel;
    logic                        cfg_wr;
    lmt_pkg::ctrl_cmd_t          cmd;
    lmt_pkg::ctrl_stat_t         stat;

    // Configuration registers
    assign pready  = 1'b1;
    assign reg_sel = lmt_pkg::reg_sel_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= lmt_pkg::TIMEOUT_RST;
            max_entries_reg <= lmt_pkg::MAXE_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                lmt_pkg::REG_TIMEOUT: timeout_reg     <= pwdata[lmt_pkg::STAMP_W-1:0];
                lmt_pkg::REG_MAXE:    max_entries_reg <= pwdata[lmt_pkg::MAXE_W-1:0];
                default:              ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (reg_sel)
            lmt_pkg::REG_TIMEOUT: prdata = lmt_pkg::APB_DATA_W'(timeout_reg);
            lmt_pkg::REG_MAXE:    prdata = lmt_pkg::APB_DATA_W'(max_entries_reg);
            default:              prdata = '0;
        endcase
    end

    // Controller
    lmt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Datapath
    lmt_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_year     (year),
        .in_month    (month),
        .in_now      (now_seconds),
        .in_evict    (do_evict),
        .timeout     (timeout_reg),
        .max_entries (max_entries_reg),
        .out_strobe  (result_valid),
        .out_valid   (evicted_valid),
        .out_year    (evicted_year),
        .out_month   (evicted_month),
        .out_cause   (evict_cause),
        .out_last    (last_result)
    );

endmodule
